/* rtl/gfm_pkg.sv */
// Shared types and constants of the gated frequency meter.
package gfm_pkg;

    // Field and datapath widths
    localparam int GFM_EDGE_W        = 16;
    localparam int GFM_CFG_W         = 16;
    localparam int GFM_PULSE_W       = 32;
    localparam int GFM_PROD_W        = 46;   // pulse total times 16000
    localparam int GFM_FREQ_W        = 48;
    localparam int GFM_DIV_W         = 16;   // divisor width of the serial divider
    localparam int GFM_HISTORY_DEPTH = 5;

    // Register reset values
    localparam logic [GFM_CFG_W-1:0] GFM_GATE_RESET = 16'd1000;
    localparam logic [GFM_CFG_W-1:0] GFM_LOSS_RESET = 16'd2000;

    // Register select (paddr bit 2)
    localparam logic GFM_REG_GATE_MS      = 1'b0;
    localparam logic GFM_REG_LOSS_TIMEOUT = 1'b1;

    // One tick on the input channel
    typedef struct packed {
        logic [GFM_EDGE_W-1:0] edges;
        logic                  clear_request;
    } t_gfm_in;

    // One result on the output channel
    typedef struct packed {
        logic                  gate_done;
        logic [GFM_FREQ_W-1:0] raw_freq_q4;
        logic [GFM_FREQ_W-1:0] smoothed_freq_q4;
        logic                  signal_present;
    } t_gfm_out;

    // Configuration register contents
    typedef struct packed {
        logic [GFM_CFG_W-1:0] gate_ms;
        logic [GFM_CFG_W-1:0] loss_timeout_ms;
    } t_gfm_cfg;

    // Commands to the history ring
    typedef struct packed {
        logic clear;   // zero all entries and the running sum
        logic write;   // store a new sample at the current position
        logic skip;    // advance the position without a store
    } t_gfm_hist_cmd;

endpackage

/* rtl/gated_frequency_meter_core.sv */
// Top level of the gated frequency meter with a moving-average smoother.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one transfer per
// millisecond tick carrying the edge count of that tick and a clear request.
// Output channel (o_out_valid / i_out_stall / o_out_data): exactly one result
// transfer per input tick, in order.
// Configuration: APB-style port, gate_ms at 0x0 and loss_timeout_ms at 0x4.
// Flow: a tick that does not close a gate goes from S_PUSH into the output
// register. A closing tick runs a constant multiply (S_MUL1, S_MUL2), a serial
// division by the gate length, a ring update (S_HIST, S_HIST_WAIT) and a serial
// division by the history depth; each division yields a quotient of
// 48 + clog2(HISTORY_DEPTH) bits (51 by default), one bit per step. A tick
// that closes a gate with the signal lost skips all of that and goes to S_PUSH.
// One tick is in work at a time: o_in_stall is high from the transfer until
// its result is loaded into the output register. The next tick is taken while
// that result waits; if the receiver stalls, the following result waits in
// the block until the output register is free.
// Reset clears the counters, the ring, the held results and the registers to
// their defaults; the block is ready in the cycle after reset.
module gated_frequency_meter_core #(
    parameter int HISTORY_DEPTH = gfm_pkg::GFM_HISTORY_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gfm_pkg::t_gfm_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gfm_pkg::t_gfm_out  o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import gfm_pkg::*;

    localparam int SUM_W = GFM_FREQ_W + $clog2(HISTORY_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL1, S_MUL2, S_DIV_RAW, S_HIST, S_HIST_WAIT, S_DIV_SUM, S_PUSH
    } t_state;

    t_state                r_state;
    logic [GFM_CFG_W-1:0]  r_gate_ticks;
    logic [GFM_PULSE_W-1:0] r_pulse;
    logic [GFM_CFG_W-1:0]  r_tse;
    logic [GFM_PROD_W-1:0] r_prod;
    logic [GFM_FREQ_W-1:0] r_held_raw;
    logic [GFM_FREQ_W-1:0] r_held_smooth;
    logic                  r_present;
    logic                  r_done_flag;
    logic                  r_div_go;
    logic                  r_div_sel;
    logic                  r_out_valid;
    t_gfm_out              r_out_data;

    t_gfm_cfg              w_cfg;
    t_gfm_hist_cmd         w_hist_cmd;
    logic [SUM_W-1:0]      w_hist_sum;
    logic                  w_accept;
    logic [GFM_PULSE_W-1:0] w_pulse_base;
    logic [GFM_PULSE_W:0]  w_pulse_sum;
    logic [GFM_PULSE_W-1:0] n_pulse;
    logic [GFM_CFG_W-1:0]  n_tse;
    logic [GFM_CFG_W-1:0]  w_gate_len;
    logic [GFM_CFG_W-1:0]  w_gate_next;
    logic                  w_close;
    logic                  w_lost;
    logic [SUM_W-1:0]      w_dividend;
    logic [GFM_DIV_W-1:0]  w_divisor;
    logic                  w_div_busy;
    logic                  w_div_done;
    logic [SUM_W-1:0]      w_quo;
    logic                  w_out_load;

    // Configuration registers
    gfm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Tick bookkeeping on the transfer
    assign w_accept     = i_in_valid & ~o_in_stall;
    assign w_pulse_base = i_in_data.clear_request ? '0 : r_pulse;
    assign w_pulse_sum  = {1'b0, w_pulse_base} + (GFM_PULSE_W + 1)'(i_in_data.edges);
    assign n_pulse      = w_pulse_sum[GFM_PULSE_W] ? '1 : w_pulse_sum[GFM_PULSE_W-1:0];
    assign n_tse        = (i_in_data.edges != '0) ? '0 :
                          ((r_tse == '1) ? r_tse : r_tse + GFM_CFG_W'(1));
    assign w_gate_len   = (w_cfg.gate_ms == '0) ? GFM_CFG_W'(1) : w_cfg.gate_ms;
    assign w_gate_next  = r_gate_ticks + GFM_CFG_W'(1);
    assign w_close      = (w_gate_next >= w_gate_len) || (w_gate_next == '0);
    assign w_lost       = (n_tse > w_cfg.loss_timeout_ms);

    // Ring commands
    assign w_hist_cmd.clear = w_accept & (i_in_data.clear_request | (w_close & w_lost));
    assign w_hist_cmd.skip  = w_accept & w_close & w_lost;
    assign w_hist_cmd.write = (r_state == S_HIST);

    gfm_history #(
        .DEPTH (HISTORY_DEPTH),
        .SUM_W (SUM_W)
    ) u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_hist_cmd),
        .i_raw   (r_held_raw),
        .o_sum   (w_hist_sum)
    );

    // Shared divider: gate length for the raw value, depth for the average
    assign w_dividend = r_div_sel ? w_hist_sum : SUM_W'(r_prod);
    assign w_divisor  = r_div_sel ? GFM_DIV_W'(HISTORY_DEPTH) : w_gate_len;

    gfm_serial_div #(
        .DW (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Output register takes a new result when empty or draining
    assign w_out_load = (r_state == S_PUSH) && (!r_out_valid || !i_out_stall);

    // Sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_gate_ticks  <= '0;
            r_pulse       <= '0;
            r_tse         <= '0;
            r_prod        <= '0;
            r_held_raw    <= '0;
            r_held_smooth <= '0;
            r_present     <= 1'b0;
            r_done_flag   <= 1'b0;
            r_div_go      <= 1'b0;
            r_div_sel     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_data    <= '0;
        end else begin
            r_div_go <= (r_state == S_MUL2) || (r_state == S_HIST_WAIT);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_tse <= n_tse;
                        if (w_close) begin
                            r_gate_ticks <= '0;
                            r_done_flag  <= 1'b1;
                            if (w_lost) begin
                                // lost: outputs read zero, ring already cleared
                                r_pulse       <= '0;
                                r_held_raw    <= '0;
                                r_held_smooth <= '0;
                                r_present     <= 1'b0;
                                r_state       <= S_PUSH;
                            end else begin
                                r_pulse <= n_pulse;
                                r_state <= S_MUL1;
                            end
                        end else begin
                            r_gate_ticks <= w_gate_next;
                            r_pulse      <= n_pulse;
                            r_done_flag  <= 1'b0;
                            r_state      <= S_PUSH;
                        end
                    end
                end
                // pulse * 16000 = pulse * (16384 - 256 - 128)
                S_MUL1: begin
                    r_prod  <= {r_pulse, 14'd0} - {6'd0, r_pulse, 8'd0};
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod    <= r_prod - {7'd0, r_pulse, 7'd0};
                    r_div_sel <= 1'b0;
                    r_state   <= S_DIV_RAW;
                end
                S_DIV_RAW: begin
                    if (w_div_done) begin
                        r_held_raw <= w_quo[GFM_FREQ_W-1:0];
                        r_pulse    <= '0;
                        r_state    <= S_HIST;
                    end
                end
                S_HIST: begin
                    r_state <= S_HIST_WAIT;
                end
                S_HIST_WAIT: begin
                    r_div_sel <= 1'b1;
                    r_state   <= S_DIV_SUM;
                end
                S_DIV_SUM: begin
                    if (w_div_done) begin
                        r_held_smooth <= w_quo[GFM_FREQ_W-1:0];
                        r_present     <= 1'b1;
                        r_state       <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_out_load) begin
                        r_out_data.gate_done        <= r_done_flag;
                        r_out_data.raw_freq_q4      <= r_held_raw;
                        r_out_data.smoothed_freq_q4 <= r_held_smooth;
                        r_out_data.signal_present   <= r_present;
                        r_state                     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // No tick is taken while a division runs
    a_no_accept_while_dividing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_div_busy |-> o_in_stall
    ) else $error("input taken while divider busy");

    // A result without signal carries zero frequencies
    a_lost_reads_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.signal_present) |->
            (o_out_data.raw_freq_q4 == '0 && o_out_data.smoothed_freq_q4 == '0)
    ) else $error("nonzero frequency without signal");

    // While idle without signal the ring holds nothing
    a_empty_ring_when_lost: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_present) |-> (w_hist_sum == '0)
    ) else $error("ring sum nonzero without signal");

endmodule

/* rtl/gfm_regs.sv */
// APB-style configuration registers of the gated frequency meter.
module gfm_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output gfm_pkg::t_gfm_cfg   o_cfg
);
    import gfm_pkg::*;

    logic [GFM_CFG_W-1:0] r_gate_ms;
    logic [GFM_CFG_W-1:0] r_loss_timeout;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // Register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_ms      <= GFM_GATE_RESET;
            r_loss_timeout <= GFM_LOSS_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                GFM_REG_GATE_MS:      r_gate_ms      <= pwdata[GFM_CFG_W-1:0];
                GFM_REG_LOSS_TIMEOUT: r_loss_timeout <= pwdata[GFM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[2])
            GFM_REG_GATE_MS:      prdata = {16'd0, r_gate_ms};
            GFM_REG_LOSS_TIMEOUT: prdata = {16'd0, r_loss_timeout};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.gate_ms         = r_gate_ms;
    assign o_cfg.loss_timeout_ms = r_loss_timeout;

endmodule

/* rtl/gfm_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per clock.
module gfm_serial_div #(
    parameter int DW = 51
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DW-1:0]                 i_dividend,
    input  logic [gfm_pkg::GFM_DIV_W-1:0] i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [DW-1:0]                 o_quotient
);
    import gfm_pkg::*;

    localparam int CW = $clog2(DW + 1);

    typedef enum logic {DV_IDLE, DV_RUN} t_dv_state;

    t_dv_state            r_state;
    logic [GFM_DIV_W-1:0] r_rem;
    logic [GFM_DIV_W-1:0] r_div;
    logic [DW-1:0]        r_quo;   // dividend shifts out, quotient shifts in
    logic [CW-1:0]        r_cnt;
    logic                 r_done;
    logic [GFM_DIV_W:0]   w_trial;
    logic [GFM_DIV_W:0]   w_diff;
    logic                 w_fit;

    // One restoring step
    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_fit   = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_rem   <= '0;
            r_div   <= '0;
            r_quo   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            // done pulses after the last step
            r_done <= (r_state == DV_RUN) && (r_cnt == CW'(1));
            case (r_state)
                DV_IDLE: begin
                    if (i_start) begin
                        r_rem   <= '0;
                        r_div   <= i_divisor;
                        r_quo   <= i_dividend;
                        r_cnt   <= CW'(DW);
                        r_state <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    // remainder stays below the divisor, so 16 bits hold it
                    r_rem <= w_fit ? w_diff[GFM_DIV_W-1:0] : w_trial[GFM_DIV_W-1:0];
                    r_quo <= {r_quo[DW-2:0], w_fit};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= DV_IDLE;
                    end
                end
                default: r_state <= DV_IDLE;
            endcase
        end
    end

    assign o_busy     = (r_state == DV_RUN);
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/gfm_history.sv */
// Sample ring of the moving average with a running sum of its entries.
module gfm_history #(
    parameter int DEPTH = 5,
    parameter int SUM_W = 51
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gfm_pkg::t_gfm_hist_cmd         i_cmd,
    input  logic [gfm_pkg::GFM_FREQ_W-1:0] i_raw,
    output logic [SUM_W-1:0]               o_sum
);
    import gfm_pkg::*;

    localparam int            PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [GFM_FREQ_W-1:0] r_ring [DEPTH];
    logic [DEPTH-1:0]      r_valid;
    logic [PW-1:0]         r_pos;
    logic [SUM_W-1:0]      r_sum;
    logic [GFM_FREQ_W-1:0] r_raw_q;
    logic                  r_add_pend;
    logic [GFM_FREQ_W-1:0] w_old;
    logic [PW-1:0]         w_next_pos;

    // Entry being replaced; a cleared entry reads as zero
    assign w_old      = r_valid[r_pos] ? r_ring[r_pos] : '0;
    assign w_next_pos = (r_pos == LAST) ? '0 : r_pos + PW'(1);

    // Sample storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_ring[r_pos] <= i_raw;
            r_raw_q       <= i_raw;
        end
    end

    // Sum update in two steps: drop the old entry, then add the new one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_add_pend <= 1'b0;
        end else begin
            r_add_pend <= i_cmd.write;
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_sum   <= '0;
            end else if (i_cmd.write) begin
                r_valid[r_pos] <= 1'b1;
                r_sum          <= r_sum - SUM_W'(w_old);
            end else if (r_add_pend) begin
                r_sum <= r_sum + SUM_W'(r_raw_q);
            end
            if (i_cmd.skip || r_add_pend) begin
                r_pos <= w_next_pos;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

/* verif/tb_top.sv */
// Testbench for the gated frequency meter core: directed and random ticks against a model.
module tb_top;
    import gfm_pkg::*;

    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 9;
    localparam int BUSY_PCT          = 63;
    localparam int BOTH_PCT          = 26;
    localparam int SHOWN_MISMATCHES  = 10;
    localparam int SETTLE_CYCLES     = 20;
    localparam int RANDOM_PHASES     = 8;
    localparam int TICKS_PER_PHASE   = 140;
    localparam int CLEAR_PCT         = 3;
    localparam int SILENCE_START_PCT = 6;
    localparam longint RUN_LIMIT     = 40_000_000;

    localparam logic [2:0] ADDR_GATE_MS      = {GFM_REG_GATE_MS, 2'b00};
    localparam logic [2:0] ADDR_LOSS_TIMEOUT = {GFM_REG_LOSS_TIMEOUT, 2'b00};

    localparam logic [GFM_EDGE_W-1:0]  EDGES_MAX = '1;
    localparam logic [GFM_CFG_W-1:0]   CFG_MAX   = '1;
    localparam logic [GFM_PULSE_W-1:0] PULSE_MAX = '1;
    localparam longint unsigned        Q4_PER_KHZ = 16000;   // 1000 ms/s times 16

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // DUT ports
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_gfm_in           i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_gfm_out          o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Traffic shaping and bookkeeping
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                err_count      = 0;
    t_gfm_out          expected_results[$];

    // Meter model state
    logic [GFM_CFG_W-1:0]   mdl_gate_ms      = GFM_GATE_RESET;
    logic [GFM_CFG_W-1:0]   mdl_loss_timeout = GFM_LOSS_RESET;
    logic [GFM_CFG_W-1:0]   mdl_gate_ticks   = '0;
    logic [GFM_CFG_W-1:0]   mdl_quiet_ticks  = '0;
    logic [GFM_PULSE_W-1:0] mdl_pulse_total  = '0;
    logic [GFM_FREQ_W-1:0]  mdl_history[GFM_HISTORY_DEPTH] = '{default: '0};
    int                     mdl_ring_pos     = 0;
    logic [GFM_FREQ_W-1:0]  mdl_raw          = '0;
    logic [GFM_FREQ_W-1:0]  mdl_smoothed     = '0;
    logic                   mdl_present      = 1'b0;

    gated_frequency_meter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Receiver backpressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Advance the meter model by one tick and return the result it produces
    function automatic t_gfm_out predict_meter(input t_gfm_in tick);
        t_gfm_out               res;
        logic [GFM_PULSE_W:0]   pulse_sum;
        longint unsigned        gate_len;
        longint unsigned        product;
        longint unsigned        ring_sum;
        res      = '0;
        gate_len = (mdl_gate_ms == '0) ? 1 : mdl_gate_ms;

        if (tick.clear_request) begin
            mdl_pulse_total = '0;
            foreach (mdl_history[i]) mdl_history[i] = '0;
        end

        // saturating pulse count
        pulse_sum       = mdl_pulse_total + tick.edges;
        mdl_pulse_total = pulse_sum[GFM_PULSE_W] ? PULSE_MAX : pulse_sum[GFM_PULSE_W-1:0];

        if (tick.edges != '0) begin
            mdl_quiet_ticks = '0;
        end else if (mdl_quiet_ticks != CFG_MAX) begin
            mdl_quiet_ticks = mdl_quiet_ticks + 1'b1;
        end

        mdl_gate_ticks = mdl_gate_ticks + 1'b1;
        if (mdl_gate_ticks >= gate_len || mdl_gate_ticks == '0) begin
            res.gate_done  = 1'b1;
            mdl_gate_ticks = '0;

            product  = mdl_pulse_total;
            product  = product * Q4_PER_KHZ;
            mdl_raw  = GFM_FREQ_W'(product / gate_len);

            mdl_history[mdl_ring_pos] = mdl_raw;
            mdl_ring_pos = (mdl_ring_pos + 1) % GFM_HISTORY_DEPTH;
            ring_sum = 0;
            foreach (mdl_history[i]) ring_sum += mdl_history[i];
            mdl_smoothed = GFM_FREQ_W'(ring_sum / GFM_HISTORY_DEPTH);

            // loss zeroes the outputs and the ring; the position still advances
            if (mdl_quiet_ticks > mdl_loss_timeout) begin
                mdl_present  = 1'b0;
                mdl_raw      = '0;
                mdl_smoothed = '0;
                foreach (mdl_history[i]) mdl_history[i] = '0;
            end else begin
                mdl_present = 1'b1;
            end
            mdl_pulse_total = '0;
        end

        res.raw_freq_q4      = mdl_raw;
        res.smoothed_freq_q4 = mdl_smoothed;
        res.signal_present   = mdl_present;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input t_gfm_out exp_res,
                                   input t_gfm_out got);
        err_count++;
        if (err_count <= SHOWN_MISMATCHES) begin
            $display("%0t %s: exp done=%0b raw=%0d smooth=%0d present=%0b", $realtime, what,
                     exp_res.gate_done, exp_res.raw_freq_q4, exp_res.smoothed_freq_q4,
                     exp_res.signal_present);
            $display("    got done=%0b raw=%0d smooth=%0d present=%0b",
                     got.gate_done, got.raw_freq_q4, got.smoothed_freq_q4,
                     got.signal_present);
        end
    endtask

    // Result check on every output transfer
    always @(posedge i_clk) begin : result_check
        t_gfm_out exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected", '0, o_out_data);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out_data.gate_done !== exp_res.gate_done ||
                    o_out_data.raw_freq_q4 !== exp_res.raw_freq_q4 ||
                    o_out_data.smoothed_freq_q4 !== exp_res.smoothed_freq_q4 ||
                    o_out_data.signal_present !== exp_res.signal_present) begin
                    report_mismatch("result mismatch", exp_res, o_out_data);
                end
            end
        end
    end

    // One tick transfer; called and returns at a falling edge
    task automatic send_tick(input logic [GFM_EDGE_W-1:0] edges, input logic clr);
        t_gfm_in tick;
        tick.edges         = edges;
        tick.clear_request = clr;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tick;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_meter(tick));
        @(negedge i_clk);
    endtask

    // Drop valid and wait for all results
    task automatic wait_results_drained;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [GFM_CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (addr)
            ADDR_GATE_MS:      mdl_gate_ms      = value;
            ADDR_LOSS_TIMEOUT: mdl_loss_timeout = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Registers change only with nothing in flight
    task automatic configure_meter(input logic [GFM_CFG_W-1:0] gate,
                                   input logic [GFM_CFG_W-1:0] timeout);
        wait_results_drained();
        apb_write(ADDR_GATE_MS, gate);
        apb_write(ADDR_LOSS_TIMEOUT, timeout);
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = BUSY_PCT;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = BUSY_PCT;
            end
            default: begin
                send_idle_pct  = BOTH_PCT;
                recv_stall_pct = BOTH_PCT;
            end
        endcase
    endtask

    // Default gate is long: no gate closes, held outputs stay zero
    task automatic test_defaults_after_reset;
        send_tick(EDGES_MAX, 1'b0);
        send_tick('0, 1'b0);
        send_tick(16'd1, 1'b1);
    endtask

    // Every tick closes a gate; field extremes and ring wrap
    task automatic test_gate_of_one;
        configure_meter(16'd1, CFG_MAX);
        send_tick(EDGES_MAX, 1'b0);
        send_tick('0, 1'b0);
        send_tick(16'd1, 1'b0);
        send_tick(EDGES_MAX, 1'b0);
        send_tick(16'h5555, 1'b0);
        send_tick(16'hAAAA, 1'b0);
    endtask

    // Clear zeroes count and ring but keeps position and held values
    task automatic test_clear_request;
        send_tick(16'd300, 1'b1);
        send_tick('0, 1'b1);
    endtask

    // Gate length zero acts as one
    task automatic test_zero_gate_length;
        configure_meter('0, CFG_MAX);
        send_tick(16'd7, 1'b0);
        send_tick('0, 1'b0);
    endtask

    // Timeout zero: a closing tick without edges means loss
    task automatic test_timeout_zero;
        configure_meter(16'd1, '0);
        send_tick(16'd5, 1'b0);
        send_tick('0, 1'b0);
        send_tick(16'd3, 1'b0);
    endtask

    // Quiet exactly at the timeout stays present, beyond it is lost, then recovery
    task automatic test_signal_loss_and_recovery;
        configure_meter(16'd3, 16'd2);
        send_tick(16'd1, 1'b0);
        send_tick('0, 1'b0);
        send_tick('0, 1'b0);
        repeat (3) send_tick('0, 1'b0);
        send_tick(16'd9, 1'b0);
        send_tick('0, 1'b0);
        send_tick('0, 1'b0);
    endtask

    // Largest gate and smallest nonzero timeout, no gate closes
    task automatic test_longest_gate_setting;
        configure_meter(CFG_MAX, 16'd1);
        send_tick(EDGES_MAX, 1'b0);
        send_tick('0, 1'b0);
    endtask

    // Sender holds off until every result is back, then resumes
    task automatic test_drain_pause;
        set_idle_mode(IDLE_RECEIVER);
        configure_meter(16'd2, 16'd3);
        repeat (12) send_tick(16'($urandom_range(0, 40)), 1'b0);
        wait_results_drained();
        repeat (12) send_tick(16'($urandom_range(0, 40)), 1'b0);
    endtask

    // Random phases over several register settings and idling modes
    task automatic test_random_traffic;
        logic [GFM_CFG_W-1:0] gate;
        logic [GFM_CFG_W-1:0] timeout;
        logic [GFM_EDGE_W-1:0] edges;
        int silent_left;
        int silence_cap;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1: begin
                    gate    = 16'd1;
                    timeout = '0;
                end
                2: begin
                    gate    = '0;
                    timeout = 16'($urandom_range(0, 6));
                end
                3: begin
                    gate    = 16'd40;
                    timeout = 16'd60;
                end
                4: begin
                    gate    = 16'($urandom_range(1, 8));
                    timeout = CFG_MAX;
                end
                default: begin
                    gate    = 16'($urandom_range(1, 8));
                    timeout = 16'($urandom_range(0, 24));
                end
            endcase
            set_idle_mode(t_idle_mode'(phase % 4));
            configure_meter(gate, timeout);
            // silent stretches long enough to cross the timeout now and then
            silence_cap = (timeout > 30) ? 40 : timeout + 10;
            silent_left = 0;
            repeat (TICKS_PER_PHASE) begin
                if (silent_left == 0 && $urandom_range(99) < SILENCE_START_PCT)
                    silent_left = $urandom_range(1, silence_cap);
                if (silent_left > 0) begin
                    silent_left--;
                    edges = '0;
                end else begin
                    case ($urandom_range(3))
                        0:       edges = '0;
                        1:       edges = 16'($urandom_range(1, 16));
                        2:       edges = 16'($urandom_range(0, 65535));
                        default: edges = EDGES_MAX;
                    endcase
                end
                send_tick(edges, $urandom_range(99) < CLEAR_PCT);
            end
        end
    endtask

    // Test sequence
    initial begin
        set_idle_mode(IDLE_NONE);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_defaults_after_reset();
        test_gate_of_one();
        test_clear_request();
        test_zero_gate_length();
        test_timeout_zero();
        test_signal_loss_and_recovery();
        test_longest_gate_setting();
        test_drain_pause();
        test_random_traffic();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #RUN_LIMIT;
        $display("Regression FAIL");
        $finish;
    end

endmodule
